### hdl/sls_pkg.sv
`default_nettype none

package sls_pkg;

  // List storage
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Item field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned FOUND_W = 6;
  localparam int unsigned FILL_W  = 7;

  // Stream packing
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } sls_cmd_e;

  typedef struct packed {
    sls_cmd_e                   cmd;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;
  } sls_item_t;

  typedef struct packed {
    logic                       ok;
    logic signed [VALUE_W-1:0]  read_value;
    logic        [FOUND_W-1:0]  found_at;
    logic        [FILL_W-1:0]   fill_count;
  } sls_result_t;

endpackage

`default_nettype wire

### hdl/sls_front.sv
`default_nettype none

module sls_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // value[31:0], position[37:32], zero fill above
  input  wire  [sls_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  wire  [sls_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                           push_valid_o,
  input  wire                            push_ready_i,
  output sls_pkg::sls_item_t             push_item_o
);
  import sls_pkg::*;

  logic      vld_q, vld_d;
  sls_item_t item_q, item_d;
  logic      take;

  assign s_axis_tready_o = !vld_q || push_ready_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the stream word into the queue item
  always_comb begin
    item_d          = item_q;
    vld_d           = vld_q;
    if (vld_q && push_ready_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d          = 1'b1;
      item_d.cmd      = sls_cmd_e'(s_axis_tuser_i);
      item_d.value    = s_axis_tdata_i[VALUE_W-1:0];
      item_d.position = s_axis_tdata_i[VALUE_W +: POS_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = vld_q;
  assign push_item_o  = item_q;

endmodule

`default_nettype wire

### hdl/sls_queue.sv
`default_nettype none

module sls_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  sls_pkg::sls_item_t  push_item_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output sls_pkg::sls_item_t  pop_item_o
);
  import sls_pkg::*;

  sls_item_t          slots_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### hdl/sls_back.sv
`default_nettype none

module sls_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 pop_valid_i,
  output logic                pop_ready_o,
  input  sls_pkg::sls_item_t  pop_item_i,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output sls_pkg::sls_result_t res_o
);
  import sls_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [VALUE_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]          scan_q, scan_d;
  logic                      cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic                      out_vld_q, out_vld_d;
  sls_result_t               out_q, out_d;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_q;
  logic                      rd_en, wr_en;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic                      out_free, pop;
  logic                      load;
  sls_result_t               res;

  assign out_free    = !out_vld_q || res_ready_i;
  assign pop_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    scan_d    = scan_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = cnt_q[ADDR_W-1:0];
    load      = 1'b0;
    res       = '0;

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (pop_item_i.cmd)
            CMD_APPEND: begin
              load = 1'b1;
              if (cnt_q < CNT_W'(DEPTH)) begin
                wr_en  = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                res.ok = 1'b1;
              end
              res.fill_count = FILL_W'(cnt_d);
            end
            CMD_READ: begin
              if (CNT_W'(pop_item_i.position) < cnt_q) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(pop_item_i.position);
                state_d = ST_READ;
              end else begin
                load           = 1'b1;
                res.fill_count = FILL_W'(cnt_q);
              end
            end
            CMD_LOCATE: begin
              if (cnt_q != '0) begin
                key_d   = pop_item_i.value;
                scan_d  = '0;
                state_d = ST_SCAN;
              end else begin
                load           = 1'b1;
                res.fill_count = FILL_W'(cnt_q);
              end
            end
            default: begin
              // clear: drop every entry
              cnt_d = '0;
              load  = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load           = 1'b1;
        res.ok         = 1'b1;
        res.read_value = rd_data_q;
        res.fill_count = FILL_W'(cnt_q);
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        // issue one address a cycle, compare the word read the cycle before
        if (scan_q < cnt_q) begin
          rd_en     = 1'b1;
          rd_addr   = scan_q[ADDR_W-1:0];
          scan_d    = scan_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[ADDR_W-1:0];
        end
        res.fill_count = FILL_W'(cnt_q);
        if (cmp_vld_q && (rd_data_q == key_q)) begin
          load         = 1'b1;
          res.ok       = 1'b1;
          res.found_at = FOUND_W'(cmp_idx_q);
          state_d      = ST_IDLE;
          cmp_vld_d    = 1'b0;
        end else if (cmp_vld_q && ((CNT_W'(cmp_idx_q) + 1'b1) == cnt_q)) begin
          load      = 1'b1;
          state_d   = ST_IDLE;
          cmp_vld_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_vld_q && res_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    cmp_idx_q <= cmp_idx_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= pop_item_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

### hdl/sequential_list_store.sv
// Path: each command passes the front register and the queue to the output register;
//   a read adds the memory read register, a locate a scan to the first match or list end.
// Throughput: one append or clear per cycle while the output is taken; a locate holds the
//   back end while it scans the entries through the single read port of the entry memory.
// Reset: asynchronous, active low; empties the list and the queue. Entries are not cleared.
`default_nettype none

module sequential_list_store (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // value[31:0], position[37:32], zero fill [39:38]
  input  wire  [sls_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // cmd[1:0]
  input  wire  [sls_pkg::CMD_W-1:0]       s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // read_value[31:0], found_at[37:32], fill_count[44:38], zero fill [47:45]
  output logic [sls_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // ok[0]
  output logic [0:0]                      m_axis_tuser_o
);
  import sls_pkg::*;

  logic        push_valid, push_ready;
  sls_item_t   push_item;
  logic        pop_valid, pop_ready;
  sls_item_t   pop_item;
  sls_result_t res;

  sls_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  sls_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  sls_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = {
    (OUT_DATA_W - VALUE_W - FOUND_W - FILL_W)'(0),
    res.fill_count, res.found_at, res.read_value
  };
  assign m_axis_tuser_o = res.ok;

  ap_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.fill_count <= FILL_W'(DEPTH)))
    else $error("fill count above capacity");

  ap_read_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ((res.read_value != '0) || (res.found_at != '0))) |-> res.ok)
    else $error("read value or position reported without success");

  ap_empty_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res.fill_count == '0)) |-> !res.ok)
    else $error("success reported on an empty list");

  ap_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && !pop_ready) |=> pop_valid)
    else $error("queue head lost while back end busy");

endmodule

`default_nettype wire

### verif/sequential_list_store_tb.sv
`timescale 1ns / 1ps

module sequential_list_store_tb;
  import sls_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 106;

  typedef struct {
    sls_cmd_e             cmd;
    logic [VALUE_W-1:0]   value;
    logic [POS_W-1:0]     position;
    int                   repeats;
    bit                   typed;
    sls_result_t          typed_res;
  } list_row_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  // Predictor copy of the list
  logic [VALUE_W-1:0]     list_words [DEPTH];
  int                     list_fill = 0;

  sls_result_t            pending_results [$];
  list_row_t              directed_rows [$];

  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_refusals = 0;
  int locate_hits = 0;
  int read_hits = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  sequential_list_store uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic sls_result_t list_res(input logic ok, input logic [VALUE_W-1:0] rd,
                                           input logic [FOUND_W-1:0] at,
                                           input logic [FILL_W-1:0] fill);
    sls_result_t r;
    r.ok         = ok;
    r.read_value = rd;
    r.found_at   = at;
    r.fill_count = fill;
    return r;
  endfunction

  // Apply one command to the predictor list and return the result it causes
  task automatic predict_list_op(input sls_item_t it, output sls_result_t r);
    r = '0;
    case (it.cmd)
      CMD_APPEND: begin
        if (list_fill < DEPTH) begin
          list_words[list_fill] = it.value;
          list_fill++;
          r.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      CMD_READ: begin
        if (int'(it.position) < list_fill) begin
          r.read_value = list_words[it.position];
          r.ok = 1'b1;
          read_hits++;
        end
      end
      CMD_LOCATE: begin
        for (int i = 0; i < list_fill; i++) begin
          if (!r.ok && list_words[i] == it.value) begin
            r.ok = 1'b1;
            r.found_at = FOUND_W'(i);
          end
        end
        if (r.ok) locate_hits++;
      end
      default: list_fill = 0;
    endcase
    r.fill_count = FILL_W'(list_fill);
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Offer one item, idling at random beforehand; record its expectation once taken
  task automatic send_list_op(input sls_item_t it, input bit typed, input sls_result_t typed_res);
    sls_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.position, it.value};
    s_axis_tuser  <= it.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_list_op(it, r);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  function automatic sls_item_t pick_list_op(input int clear_pct);
    sls_item_t it;
    int roll;
    it.value    = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 7)) : $urandom;
    it.position = POS_W'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < clear_pct) begin
      it.cmd = CMD_CLEAR;
    end else if (roll < 45) begin
      it.cmd = CMD_APPEND;
    end else if (roll < 72) begin
      it.cmd = CMD_READ;
      if (list_fill > 0 && $urandom_range(0, 3) != 0)
        it.position = POS_W'($urandom_range(0, list_fill - 1));
    end else begin
      it.cmd = CMD_LOCATE;
      if (list_fill > 0 && $urandom_range(0, 1) == 1)
        it.value = list_words[$urandom_range(0, list_fill - 1)];
    end
    return it;
  endfunction

  task automatic check_list_result();
    sls_result_t want;
    logic [VALUE_W-1:0] got_rd;
    logic [FOUND_W-1:0] got_at;
    logic [FILL_W-1:0]  got_fill;
    got_rd   = m_axis_tdata[31:0];
    got_at   = m_axis_tdata[37:32];
    got_fill = m_axis_tdata[44:38];
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing expected");
    end else begin
      want = pending_results.pop_front();
      if (m_axis_tuser[0] !== want.ok)
        report_mismatch($sformatf("ok got %0b want %0b", m_axis_tuser[0], want.ok));
      if (got_rd !== want.read_value)
        report_mismatch($sformatf("read_value got %h want %h", got_rd, want.read_value));
      if (got_at !== want.found_at)
        report_mismatch($sformatf("found_at got %0d want %0d", got_at, want.found_at));
      if (got_fill !== want.fill_count)
        report_mismatch($sformatf("fill_count got %0d want %0d", got_fill, want.fill_count));
    end
  endtask

  // Receiver: check each result, stall at random or for a long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_list_result();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
    $display("sequential_list_store_tb: done, errors");
    $finish;
  end

  initial begin
    sls_item_t it;
    list_row_t row;
    int clear_pct [3];
    clear_pct = '{1, 4, 2};

    directed_rows.push_back('{CMD_READ,   32'h0000_0000, 6'd0,  1, 1'b1, list_res(0, 0, 0, 0)});
    directed_rows.push_back('{CMD_LOCATE, 32'h0000_0000, 6'd0,  1, 1'b1, list_res(0, 0, 0, 0)});
    directed_rows.push_back('{CMD_APPEND, 32'h8000_0000, 6'd0,  1, 1'b1, list_res(1, 0, 0, 1)});
    directed_rows.push_back('{CMD_APPEND, 32'h7FFF_FFFF, 6'd63, 1, 1'b1, list_res(1, 0, 0, 2)});
    directed_rows.push_back('{CMD_APPEND, 32'hFFFF_FFFF, 6'd0,  1, 1'b1, list_res(1, 0, 0, 3)});
    // duplicate word: locate must return the lower index
    directed_rows.push_back('{CMD_APPEND, 32'h7FFF_FFFF, 6'd0,  1, 1'b1, list_res(1, 0, 0, 4)});
    directed_rows.push_back('{CMD_READ,   32'h0000_0000, 6'd0,  1, 1'b0, '0});
    directed_rows.push_back('{CMD_READ,   32'hFFFF_FFFF, 6'd3,  1, 1'b0, '0});
    directed_rows.push_back('{CMD_READ,   32'h0000_0000, 6'd4,  1, 1'b1, list_res(0, 0, 0, 4)});
    directed_rows.push_back('{CMD_READ,   32'h0000_0000, 6'd63, 1, 1'b1, list_res(0, 0, 0, 4)});
    directed_rows.push_back('{CMD_LOCATE, 32'h7FFF_FFFF, 6'd0,  1, 1'b0, '0});
    directed_rows.push_back('{CMD_LOCATE, 32'h1234_5678, 6'd0,  1, 1'b1, list_res(0, 0, 0, 4)});
    directed_rows.push_back('{CMD_CLEAR,  32'hFFFF_FFFF, 6'd63, 1, 1'b1, list_res(0, 0, 0, 0)});
    directed_rows.push_back('{CMD_READ,   32'h0000_0000, 6'd0,  1, 1'b1, list_res(0, 0, 0, 0)});
    directed_rows.push_back('{CMD_LOCATE, 32'h8000_0000, 6'd0,  1, 1'b1, list_res(0, 0, 0, 0)});
    // fill to capacity with ascending words
    directed_rows.push_back('{CMD_APPEND, 32'h0000_0100, 6'd0,  DEPTH, 1'b0, '0});
    directed_rows.push_back('{CMD_APPEND, 32'h0000_0000, 6'd0,  1, 1'b1, list_res(0, 0, 0, 64)});
    directed_rows.push_back('{CMD_READ,   32'h0000_0000, 6'd63, 1, 1'b0, '0});
    directed_rows.push_back('{CMD_LOCATE, 32'h0000_013F, 6'd0,  1, 1'b0, '0});
    directed_rows.push_back('{CMD_LOCATE, 32'h0000_0100, 6'd0,  1, 1'b0, '0});
    directed_rows.push_back('{CMD_CLEAR,  32'h0000_0000, 6'd0,  1, 1'b1, list_res(0, 0, 0, 0)});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 67;
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < row.repeats; k++) begin
        it.cmd      = row.cmd;
        it.value    = row.value + VALUE_W'(k);
        it.position = row.position;
        send_list_op(it, row.typed, row.typed_res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 36 : 0;
      // back-pressure the output so the block fills and stalls its input
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_list_op(pick_list_op(clear_pct[ph]), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);

    $display("sequential_list_store_tb: %0d items sent, %0d results checked", items_sent,
             results_seen);
    $display({"sequential_list_store_tb: %0d refused appends on a full list, ",
              "%0d locate hits, %0d valid reads"},
             full_refusals, locate_hits, read_hits);
    if (error_count == 0) begin
      $display("sequential_list_store_tb: done, clean");
    end else begin
      $display("sequential_list_store_tb: done, errors");
    end
    $finish;
  end

endmodule
